// ----- rtl/srcls_pkg.sv -----
// Shared constants and types for the set relation classifier.
package srcls_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int ELEM_W = 64;

  typedef enum logic [2:0] {
    REL_EQUAL    = 3'd0,
    REL_DISJOINT = 3'd1,
    REL_A_IN_B   = 3'd2,
    REL_B_IN_A   = 3'd3,
    REL_CONFUSED = 3'd4
  } relation_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUTER,
    S_KEY,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ----- rtl/set_relation_classifier_unit.sv -----
// Set relation classifier: element store, pairwise search sequencer, result register.
//
// Usage: drive an element on the in_ ports and pulse start while busy is low.
// Items without in_end_of_pair load one element per cycle (busy stays low).
// An item with in_end_of_pair adds its element (if in_has_element), then
// raises busy while both sets are searched element by element against one
// shared 64-bit comparator: every element of the outer set is read from its
// memory, then the other set is scanned one entry per cycle until a hit or
// its end. Pass one runs A against B, pass two B against A.
// The memory read port and the one comparator set the search time; busy drops
// in the cycle the result is shown.
// The result sits on out_relation / out_capacity_exceeded for one cycle with
// out_valid high; there is no backpressure on it. Both sets and the overflow
// flag are cleared after each result.
// Reset (rst_n low, synchronous) empties both sets and returns to idle;
// store contents are not cleared, only the fill counts.
module set_relation_classifier_unit
  import srcls_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic                     in_into_set_b,
  input  logic                     in_has_element,
  input  logic                     in_end_of_pair,
  output logic                     out_valid,
  output logic [2:0]               out_relation,
  output logic                     out_capacity_exceeded
);

  // element stores
  logic [ELEM_W-1:0] mem_a [MAX_ELEMENTS];
  logic [ELEM_W-1:0] mem_b [MAX_ELEMENTS];
  logic [ELEM_W-1:0] rd_a_q, rd_b_q;

  state_t    state_r, state_nxt;
  logic      pass_r, pass_nxt;
  logic [CNT_W-1:0] idx_i_r, idx_i_nxt;
  logic [CNT_W-1:0] idx_j_r, idx_j_nxt;
  logic [CNT_W-1:0] count_a_r, count_a_nxt;
  logic [CNT_W-1:0] count_b_r, count_b_nxt;
  logic      ovf_r, ovf_nxt;
  logic      a_in_b_r, a_in_b_nxt;
  logic      any_r, any_nxt;
  logic      b_in_a_r, b_in_a_nxt;
  logic      out_valid_r, out_valid_nxt;
  relation_t relation_r, relation_nxt;
  logic      cap_r, cap_nxt;

  logic             wr_a_en, wr_b_en;
  logic             rd_a_en, rd_b_en;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  logic             rd_outer_en, rd_inner_en;
  logic [ADDR_W-1:0] outer_addr, inner_addr;
  logic [CNT_W-1:0] outer_cnt, inner_cnt;
  logic [CNT_W-1:0] j_inc;
  logic [ELEM_W-1:0] outer_q, inner_q;
  logic             elem_done, elem_found;
  logic             accept;

  assign accept    = start && (state_r == S_IDLE);
  assign outer_cnt = pass_r ? count_b_r : count_a_r;
  assign inner_cnt = pass_r ? count_a_r : count_b_r;
  assign outer_q   = pass_r ? rd_b_q : rd_a_q;
  assign inner_q   = pass_r ? rd_a_q : rd_b_q;
  assign j_inc     = idx_j_r + CNT_W'(1);

  // loads use the write port, the search uses the read port
  assign wr_a_en = accept && in_has_element && !in_into_set_b
                   && (count_a_r < CNT_W'(MAX_ELEMENTS));
  assign wr_b_en = accept && in_has_element && in_into_set_b
                   && (count_b_r < CNT_W'(MAX_ELEMENTS));

  assign rd_a_en   = pass_r ? rd_inner_en : rd_outer_en;
  assign rd_b_en   = pass_r ? rd_outer_en : rd_inner_en;
  assign rd_a_addr = pass_r ? inner_addr : outer_addr;
  assign rd_b_addr = pass_r ? outer_addr : inner_addr;

  always_ff @(posedge clk) begin
    if (wr_a_en) begin
      mem_a[count_a_r[ADDR_W-1:0]] <= in_element_value;
    end
    if (rd_a_en) begin
      rd_a_q <= mem_a[rd_a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b_en) begin
      mem_b[count_b_r[ADDR_W-1:0]] <= in_element_value;
    end
    if (rd_b_en) begin
      rd_b_q <= mem_b[rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      idx_i_r     <= '0;
      idx_j_r     <= '0;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ovf_r       <= 1'b0;
      a_in_b_r    <= 1'b1;
      any_r       <= 1'b0;
      b_in_a_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      idx_i_r     <= idx_i_nxt;
      idx_j_r     <= idx_j_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      ovf_r       <= ovf_nxt;
      a_in_b_r    <= a_in_b_nxt;
      any_r       <= any_nxt;
      b_in_a_r    <= b_in_a_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    relation_r <= relation_nxt;
    cap_r      <= cap_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    idx_i_nxt     = idx_i_r;
    idx_j_nxt     = idx_j_r;
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    ovf_nxt       = ovf_r;
    a_in_b_nxt    = a_in_b_r;
    any_nxt       = any_r;
    b_in_a_nxt    = b_in_a_r;
    out_valid_nxt = 1'b0;
    relation_nxt  = relation_r;
    cap_nxt       = cap_r;
    rd_outer_en   = 1'b0;
    rd_inner_en   = 1'b0;
    outer_addr    = idx_i_r[ADDR_W-1:0];
    inner_addr    = '0;
    elem_done     = 1'b0;
    elem_found    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_has_element) begin
            if (in_into_set_b) begin
              if (wr_b_en) count_b_nxt = count_b_r + CNT_W'(1);
              else         ovf_nxt = 1'b1;
            end else begin
              if (wr_a_en) count_a_nxt = count_a_r + CNT_W'(1);
              else         ovf_nxt = 1'b1;
            end
          end
          if (in_end_of_pair) begin
            state_nxt  = S_OUTER;
            pass_nxt   = 1'b0;
            idx_i_nxt  = '0;
            a_in_b_nxt = 1'b1;
            any_nxt    = 1'b0;
            b_in_a_nxt = 1'b1;
          end
        end
      end
      S_OUTER: begin
        if (idx_i_r == outer_cnt) begin
          if (!pass_r) begin
            pass_nxt  = 1'b1;
            idx_i_nxt = '0;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          rd_outer_en = 1'b1;
          state_nxt   = S_KEY;
        end
      end
      S_KEY: begin
        // outer element now in its read register; start the scan
        if (inner_cnt == '0) begin
          elem_done = 1'b1;
        end else begin
          rd_inner_en = 1'b1;
          inner_addr  = '0;
          idx_j_nxt   = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (inner_q == outer_q) begin
          elem_done  = 1'b1;
          elem_found = 1'b1;
        end else if (j_inc == inner_cnt) begin
          elem_done = 1'b1;
        end else begin
          rd_inner_en = 1'b1;
          inner_addr  = j_inc[ADDR_W-1:0];
          idx_j_nxt   = j_inc;
        end
      end
      S_DONE: begin
        priority if ((count_a_r == count_b_r) && a_in_b_r && b_in_a_r) begin
          relation_nxt = REL_EQUAL;
        end else if (!any_r) begin
          relation_nxt = REL_DISJOINT;
        end else if (count_a_r <= count_b_r) begin
          relation_nxt = a_in_b_r ? REL_A_IN_B : REL_CONFUSED;
        end else begin
          relation_nxt = b_in_a_r ? REL_B_IN_A : REL_CONFUSED;
        end
        cap_nxt       = ovf_r;
        out_valid_nxt = 1'b1;
        count_a_nxt   = '0;
        count_b_nxt   = '0;
        ovf_nxt       = 1'b0;
        pass_nxt      = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (elem_done) begin
      if (!pass_r) begin
        a_in_b_nxt = a_in_b_r & elem_found;
        any_nxt    = any_r | elem_found;
      end else begin
        b_in_a_nxt = b_in_a_r & elem_found;
      end
      idx_i_nxt = idx_i_r + CNT_W'(1);
      state_nxt = S_OUTER;
    end
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_relation          = relation_r;
  assign out_capacity_exceeded = cap_r;

endmodule
